// File: rtl/idq_pkg.sv
// ----------------------------------------------------------------------------
// idq_pkg
// Shared types and constants for the indexed deque store: request and
// response items, status and request codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package idq_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);

   typedef enum logic [2:0] {
      REQ_APPEND     = 3'd0,
      REQ_PREPEND    = 3'd1,
      REQ_DEL_LAST   = 3'd2,
      REQ_DEL_FIRST  = 3'd3,
      REQ_READ_AT    = 3'd4,
      REQ_INSERT_AT  = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADPOS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_LOAD       = 2'd1,
      CELL_FROM_LOWER = 2'd2,
      CELL_FROM_UPPER = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [3:0]         position;
      logic signed [31:0] value;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [4:0]         count;
   } rsp_item_type;

endpackage

// File: rtl/idq_cell.sv
// ----------------------------------------------------------------------------
// idq_cell
// One storage cell of the chain: holds one element, loads a new value or
// takes the value of its lower or upper neighbor.
// ----------------------------------------------------------------------------
module idq_cell (
   input  logic                              clock,
   input  idq_pkg::cell_ctrl_type            ctrl,
   input  logic signed [idq_pkg::DATA_W-1:0] lower_value,
   input  logic signed [idq_pkg::DATA_W-1:0] upper_value,
   output logic signed [idq_pkg::DATA_W-1:0] value_out
);
   import idq_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   always_comb begin
      case (ctrl.op)
         CELL_LOAD:       value_in = ctrl.value;
         CELL_FROM_LOWER: value_in = lower_value;
         CELL_FROM_UPPER: value_in = upper_value;
         default:         value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

// File: rtl/idq_out_buf.sv
// ----------------------------------------------------------------------------
// idq_out_buf
// Two-entry response buffer: an output register plus a skid slot, so a new
// item can be taken while a finished response waits on a stalled receiver.
// ----------------------------------------------------------------------------
module idq_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  idq_pkg::rsp_item_type push_item,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_stall,
   output idq_pkg::rsp_item_type out_item
);
   import idq_pkg::*;

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type main_ff, main_in;
   rsp_item_type skid_ff, skid_in;
   logic         pop;

   assign pop = main_valid_ff && !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            // advance the skid slot
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_item;
            main_valid_in = push;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_in       = push_item;
            main_valid_in = 1'b1;
         end else begin
            // hold the new item behind the stalled one
            skid_in       = push_item;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_item  = main_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid slot holds an item while the output register is empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("item pushed while both slots are occupied");

   a_stalled_out_holds: assert property (@(posedge clock) disable iff (reset)
      main_valid_ff && out_stall |=> main_valid_ff && $stable(main_ff))
      else $error("stalled response changed");

endmodule

// File: rtl/indexed_deque_store.sv
// ----------------------------------------------------------------------------
// indexed_deque_store
// Bounded ordered store of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_data) carries one item per
//   request: append, prepend, delete last, delete first, read at position or
//   insert at position. Every request yields exactly one response item on
//   rsp_valid / rsp_stall / rsp_data with read value, status and count.
//   The response is registered; it is valid in the cycle after the request
//   is taken unless an older response is stalled in the buffer. Throughput:
//   one item per cycle while req_stall is low. On insert the cells above the
//   insert point, on delete first all cells, shift in parallel. A two-entry
//   response buffer lets one more item in while a response is stalled; once
//   both entries are full, req_stall rises until the receiver drains a response.
//   Reset: element count goes to zero and the response buffer empties.
//   Cell contents are not cleared; only cells below the count are read.
// ----------------------------------------------------------------------------
module indexed_deque_store (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  idq_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output idq_pkg::rsp_item_type rsp_data
);
   import idq_pkg::*;

   logic                     accept;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     full;
   logic                     pos_ok;
   logic [IDX_W-1:0]         read_idx;
   status_type               status;
   logic signed [DATA_W-1:0] read_value;

   // cell row control, decoded once and fanned out to every cell
   logic                     do_load;
   logic                     do_up;
   logic                     do_down;
   logic [CNT_W-1:0]         load_at;

   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic signed [DATA_W-1:0] lower_in   [CAPACITY];
   logic signed [DATA_W-1:0] upper_in   [CAPACITY];
   cell_ctrl_type            cell_ctrl  [CAPACITY];

   rsp_item_type             rsp_new;
   logic                     buf_full;

   assign accept   = req_valid && !req_stall;
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign pos_ok   = (32'(req_data.position) < 32'(count_ff));
   assign read_idx = IDX_W'(req_data.position);

   // decode the request into status, new count and cell row control
   always_comb begin
      status     = ST_OK;
      read_value = '0;
      count_in   = count_ff;
      do_load    = 1'b0;
      do_up      = 1'b0;
      do_down    = 1'b0;
      load_at    = count_ff;
      unique case (req_code_type'(req_data.req_type))
         REQ_APPEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               do_load  = 1'b1;
               load_at  = count_ff;
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_PREPEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               do_load  = 1'b1;
               do_up    = 1'b1;
               load_at  = '0;
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_DEL_LAST: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         REQ_DEL_FIRST: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               do_down  = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         REQ_READ_AT: begin
            if (!pos_ok) begin
               status = ST_BADPOS;
            end else begin
               read_value = cell_value[read_idx];
            end
         end
         REQ_INSERT_AT: begin
            // position check comes before the full check
            if (!pos_ok) begin
               status = ST_BADPOS;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               do_load  = 1'b1;
               do_up    = 1'b1;
               load_at  = CNT_W'(req_data.position);
               count_in = count_ff + CNT_W'(1);
            end
         end
         default: begin
            // unused codes change nothing
         end
      endcase
   end

   // chain of cells: each cell sees its two neighbors
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_lo_end
         assign lower_in[gi] = '0;
      end else begin : g_lo_mid
         assign lower_in[gi] = cell_value[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_hi_end
         assign upper_in[gi] = '0;
      end else begin : g_hi_mid
         assign upper_in[gi] = cell_value[gi+1];
      end

      always_comb begin
         cell_ctrl[gi].value = req_data.value;
         cell_ctrl[gi].op    = CELL_HOLD;
         if (accept) begin
            if (do_load && (CNT_W'(gi) == load_at)) begin
               cell_ctrl[gi].op = CELL_LOAD;
            end else if (do_up && (CNT_W'(gi) > load_at)) begin
               cell_ctrl[gi].op = CELL_FROM_LOWER;
            end else if (do_down) begin
               cell_ctrl[gi].op = CELL_FROM_UPPER;
            end
         end
      end

      idq_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[gi]),
         .lower_value (lower_in[gi]),
         .upper_value (upper_in[gi]),
         .value_out   (cell_value[gi])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      rsp_new.read_value = read_value;
      rsp_new.status     = status;
      rsp_new.count      = 5'(count_in);
   end

   idq_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (rsp_new),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (rsp_data)
   );

   // stall while the response buffer has no free entry
   assign req_stall = buf_full;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY)
      else $error("element count exceeds capacity");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item produced no response");

   a_count_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("element count changed without a request");

endmodule
